// ===== src/spfn_pkg.sv =====
package spfn_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int INDEX_W_DEF = 16;
    localparam int NORM_W      = 16;
    localparam int NORM_ONE    = 16384;
    localparam int E_W         = 30;   // scaled magnitude bits
    localparam int SQ_W        = 62;   // sum of three squares of E_W bits
    localparam int LEN_W       = 31;   // vector length
    localparam int REM_W       = 32;   // divider remainder
    localparam int CORNERS     = 3;
    localparam int RAD_RESET   = 65536;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } t_reg_idx;

endpackage

// ===== src/spfn_in_if.sv =====
interface spfn_in_if #(
    parameter int W = spfn_pkg::COORD_W_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] vz;

    modport source(output valid, vx, vy, vz, input ready);
    modport sink(input valid, vx, vy, vz, output ready);
endinterface

// ===== src/spfn_out_if.sv =====
interface spfn_out_if #(
    parameter int W  = spfn_pkg::COORD_W_DEF,
    parameter int IW = spfn_pkg::INDEX_W_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [W-1:0]               px;
    logic signed [W-1:0]               py;
    logic signed [W-1:0]               pz;
    logic [IW-1:0]                     vertex_index;
    logic                              normal_valid;
    logic signed [spfn_pkg::NORM_W-1:0] nx;
    logic signed [spfn_pkg::NORM_W-1:0] ny;
    logic signed [spfn_pkg::NORM_W-1:0] nz;
    logic                              degenerate_vertex;
    logic                              degenerate_face;

    modport source(output valid, px, py, pz, vertex_index, normal_valid, nx, ny, nz,
                   degenerate_vertex, degenerate_face, input ready);
    modport sink(input valid, px, py, pz, vertex_index, normal_valid, nx, ny, nz,
                 degenerate_vertex, degenerate_face, output ready);
endinterface

// ===== src/sphere_project_flat_normal.sv =====
// Sequence: a plain vertex is normalized, squared, square-rooted, then multiplied and divided
//   per component. A vertex that closes a triangle adds a cross product and a second
//   normalize/length/divide pass.
// Throughput: one request at a time on one bit-serial multiplier, one 2-bit-per-step square
//   root and one restoring divider; a result may wait in the output register meanwhile.
// Reset: synchronous active-low; config returns to center 0, radius 1.0, counters to 0.
module sphere_project_flat_normal #(
    parameter int COORD_WIDTH = spfn_pkg::COORD_W_DEF,
    parameter int INDEX_WIDTH = spfn_pkg::INDEX_W_DEF,
    localparam int DW = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int AW = (COORD_WIDTH > 32) ? 5 : 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    spfn_in_if.sink         i_vtx,
    spfn_out_if.source      o_res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [AW-1:0]   paddr,
    input  logic [DW-1:0]   pwdata,
    output logic [DW-1:0]   prdata,
    output logic            pready
);

    localparam int W     = COORD_WIDTH;
    localparam int MW    = (W + 1 > 31) ? W + 1 : 31;   // multiplier operand width
    localparam int PW    = 2 * MW;                      // product / numerator width
    localparam int CW    = PW + 1;                      // signed cross-term accumulator
    localparam int RADW  = (W - 1 > 17) ? W - 1 : 17;   // radius (holds the 1.0 reset)
    localparam int TW    = RADW + 2;                    // center +/- offset before sat
    localparam int ASH   = (COORD_WIDTH > 32) ? 3 : 2;
    localparam int CNT_W = $clog2(PW + 2);
    localparam int NW    = spfn_pkg::NORM_W;
    localparam int EW    = spfn_pkg::E_W;
    localparam int SW    = spfn_pkg::SQ_W;
    localparam int LW    = spfn_pkg::LEN_W;
    localparam int RW    = spfn_pkg::REM_W;

    localparam logic signed [TW-1:0] P_MAX = (TW'(1) <<< (W - 1)) - TW'(1);
    localparam logic signed [TW-1:0] P_MIN = -P_MAX - TW'(1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NORM  = 8'b0000_0010,
        S_SQ    = 8'b0000_0100,
        S_SQRT  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_CROSS = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // config
    logic signed [W-1:0] r_cx, r_cy, r_cz;
    logic [RADW-1:0]     r_rad;

    // per-request working set
    logic [PW-1:0]       r_m   [3];   // magnitudes being normalized
    logic                r_neg [3];   // sign of each component
    logic signed [W-1:0] r_p   [3];   // projected vertex
    logic [NW-1:0]       r_n   [3];   // normal
    logic                r_degv, r_degf, r_face;

    // held triangle corners
    logic signed [W-1:0] r_h0 [3];
    logic signed [W-1:0] r_h1 [3];
    logic [1:0]          r_corner;
    logic [INDEX_WIDTH-1:0] r_vidx;

    // sequencing
    logic [1:0]          r_idx;
    logic [2:0]          r_k;
    logic [CNT_W-1:0]    r_cnt;

    // bit-serial multiplier
    logic [MW-1:0]       r_ma, r_mpl, r_mph;
    // square root
    logic [SW-1:0]       r_sum, r_sqx, r_sqr, r_sqb;
    // restoring divider: r_dvn holds the numerator, fills with the quotient
    logic [PW-1:0]       r_dvn;
    logic [RW-1:0]       r_rem;
    // cross product term accumulator
    logic signed [CW-1:0] r_acc;

    // output register
    logic                r_ov;
    logic signed [W-1:0] r_opx, r_opy, r_opz;
    logic [INDEX_WIDTH-1:0] r_oidx;
    logic                r_onv, r_odv, r_odf;
    logic [NW-1:0]       r_onx, r_ony, r_onz;

    // ---------------------------------------------------------------- datapath
    logic signed [W-1:0] w_c  [3];
    logic signed [W:0]   w_d  [3];
    logic [W:0]          w_dm [3];
    logic signed [W:0]   w_u  [3];
    logic signed [W:0]   w_v  [3];
    logic [W:0]          w_um [3];
    logic [W:0]          w_vm [3];
    logic [EW-1:0]       w_e  [3];
    logic                w_degv, w_top, w_closing;
    logic [1:0]          w_ai, w_bi;
    logic                w_xs;
    logic [MW-1:0]       w_opa, w_opb;
    logic [MW:0]         w_ms;
    logic [PW-1:0]       w_prod;
    logic [SW-1:0]       w_sum, w_rb;
    logic [LW-1:0]       w_len;
    logic [RW-1:0]       w_trial;
    logic                w_qbit;
    logic [RADW-1:0]     w_q;
    logic signed [TW-1:0] w_t;
    logic signed [W-1:0] w_psat;
    logic [NW-1:0]       w_qn, w_nval;
    logic signed [CW-1:0] w_term, w_acc;
    logic [PW-1:0]       w_accm;

    assign w_c[0] = r_cx;
    assign w_c[1] = r_cy;
    assign w_c[2] = r_cz;

    always_comb begin
        w_d[0] = (W+1)'(i_vtx.vx) - (W+1)'(r_cx);
        w_d[1] = (W+1)'(i_vtx.vy) - (W+1)'(r_cy);
        w_d[2] = (W+1)'(i_vtx.vz) - (W+1)'(r_cz);
        for (int i = 0; i < 3; i++) begin
            w_dm[i] = w_d[i][W] ? (W+1)'(-w_d[i]) : (W+1)'(w_d[i]);
            w_u[i]  = (W+1)'(r_h1[i]) - (W+1)'(r_h0[i]);
            w_v[i]  = (W+1)'(r_p[i]) - (W+1)'(r_h0[i]);
            w_um[i] = w_u[i][W] ? (W+1)'(-w_u[i]) : (W+1)'(w_u[i]);
            w_vm[i] = w_v[i][W] ? (W+1)'(-w_v[i]) : (W+1)'(w_v[i]);
            w_e[i]  = r_m[i][PW-1 -: EW];
        end
    end

    assign w_degv    = (w_d[0] == '0) && (w_d[1] == '0) && (w_d[2] == '0);
    assign w_top     = r_m[0][PW-1] | r_m[1][PW-1] | r_m[2][PW-1];
    assign w_closing = (r_corner == 2'(spfn_pkg::CORNERS - 1));

    // cross terms: n0 = u1 v2 - u2 v1, n1 = u2 v0 - u0 v2, n2 = u0 v1 - u1 v0
    always_comb begin
        unique case (r_k)
            3'd0:    begin w_ai = 2'd1; w_bi = 2'd2; end
            3'd1:    begin w_ai = 2'd2; w_bi = 2'd1; end
            3'd2:    begin w_ai = 2'd2; w_bi = 2'd0; end
            3'd3:    begin w_ai = 2'd0; w_bi = 2'd2; end
            3'd4:    begin w_ai = 2'd0; w_bi = 2'd1; end
            3'd5:    begin w_ai = 2'd1; w_bi = 2'd0; end
            default: begin w_ai = 2'd0; w_bi = 2'd0; end
        endcase
    end
    assign w_xs = w_u[w_ai][W] ^ w_v[w_bi][W] ^ r_k[0];

    // multiplier operands by phase
    always_comb begin
        priority case (1'b1)
            r_state == S_CROSS: begin
                w_opa = MW'(w_um[w_ai]);
                w_opb = MW'(w_vm[w_bi]);
            end
            r_state == S_MUL: begin
                w_opa = MW'(w_e[r_idx]);
                w_opb = r_face ? MW'(spfn_pkg::NORM_ONE) : MW'(r_rad);
            end
            default: begin
                w_opa = MW'(w_e[r_idx]);
                w_opb = MW'(w_e[r_idx]);
            end
        endcase
    end

    assign w_ms   = {1'b0, r_mph} + (r_mpl[0] ? {1'b0, r_ma} : '0);
    assign w_prod = {r_mph, r_mpl};
    assign w_sum  = r_sum + w_prod[SW-1:0];
    assign w_rb   = r_sqr + r_sqb;
    assign w_len  = r_sqr[LW-1:0];

    assign w_trial = {r_rem[RW-2:0], r_dvn[PW-1]};
    assign w_qbit  = (w_trial >= RW'(w_len));

    // projected coordinate: center +/- rounded offset, saturated
    always_comb begin
        w_q = r_dvn[RADW-1:0];
        w_t = r_neg[r_idx] ? TW'(w_c[r_idx]) - $signed(TW'(w_q))
                           : TW'(w_c[r_idx]) + $signed(TW'(w_q));
        if (w_t > P_MAX)      w_psat = W'(P_MAX);
        else if (w_t < P_MIN) w_psat = W'(P_MIN);
        else                  w_psat = W'(w_t);
    end

    assign w_qn   = (r_dvn > PW'(spfn_pkg::NORM_ONE)) ? NW'(spfn_pkg::NORM_ONE) : r_dvn[NW-1:0];
    assign w_nval = r_neg[r_idx] ? NW'(-w_qn) : w_qn;

    assign w_term = w_xs ? -$signed({1'b0, w_prod}) : $signed({1'b0, w_prod});
    assign w_acc  = (r_k[0] ? r_acc : '0) + w_term;
    assign w_accm = w_acc[CW-1] ? PW'(-w_acc) : PW'(w_acc);

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_corner <= '0;
            r_vidx   <= '0;
            r_ov     <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_k      <= '0;
            r_face   <= 1'b0;
        end else begin
            // S_EMIT reloads the output register itself
            if (r_ov && o_res.ready && (r_state != S_EMIT)) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_vtx.valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i]   <= PW'(w_dm[i]);
                            r_neg[i] <= w_d[i][W];
                            r_p[i]   <= w_c[i];
                            r_n[i]   <= '0;
                        end
                        r_degv <= w_degv;
                        r_degf <= 1'b0;
                        r_face <= 1'b0;
                        r_k    <= '0;
                        r_cnt  <= '0;
                        // a vertex on the center keeps P = C
                        if (!w_degv)        r_state <= S_NORM;
                        else if (w_closing) r_state <= S_CROSS;
                        else                r_state <= S_EMIT;
                    end
                end

                S_NORM: begin
                    if (w_top) begin
                        r_sum   <= '0;
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end else begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end
                end

                S_SQ, S_MUL, S_CROSS: begin
                    if (r_cnt == '0) begin
                        r_ma  <= w_opa;
                        r_mpl <= w_opb;
                        r_mph <= '0;
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_cnt != CNT_W'(MW + 1)) begin
                        r_mph <= w_ms[MW:1];
                        r_mpl <= {w_ms[0], r_mpl[MW-1:1]};
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_cnt <= '0;
                        if (r_state == S_SQ) begin
                            if (r_idx == 2'd2) begin
                                r_sqx   <= w_sum;
                                r_sqr   <= '0;
                                r_sqb   <= SW'(1) << (SW - 2);
                                r_state <= S_SQRT;
                            end else begin
                                r_sum <= w_sum;
                                r_idx <= r_idx + 1'b1;
                            end
                        end else if (r_state == S_MUL) begin
                            r_dvn   <= w_prod + PW'(w_len >> 1);
                            r_rem   <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_acc <= w_acc;
                            if (r_k[0]) begin
                                r_m[r_k[2:1]]   <= w_accm;
                                r_neg[r_k[2:1]] <= w_acc[CW-1];
                            end
                            if (r_k == 3'd5) begin
                                r_face <= 1'b1;
                                if ((r_m[0] == '0) && (r_m[1] == '0) && (w_acc == '0)) begin
                                    r_degf  <= 1'b1;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_NORM;
                                end
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end
                    end
                end

                S_SQRT: begin
                    if (r_sqx >= w_rb) begin
                        r_sqx <= r_sqx - w_rb;
                        r_sqr <= (r_sqr >> 1) + r_sqb;
                    end else begin
                        r_sqr <= r_sqr >> 1;
                    end
                    r_sqb <= r_sqb >> 2;
                    if (r_cnt == CNT_W'(SW / 2 - 1)) begin
                        r_cnt   <= '0;
                        r_idx   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end

                S_DIV: begin
                    if (r_cnt != CNT_W'(PW)) begin
                        r_rem <= w_qbit ? w_trial - RW'(w_len) : w_trial;
                        r_dvn <= {r_dvn[PW-2:0], w_qbit};
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_cnt <= '0;
                        if (r_face) r_n[r_idx] <= w_nval;
                        else        r_p[r_idx] <= w_psat;
                        if (r_idx != 2'd2) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_MUL;
                        end else if (!r_face && w_closing) begin
                            r_k     <= '0;
                            r_state <= S_CROSS;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end

                S_EMIT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov   <= 1'b1;
                        r_opx  <= r_p[0];
                        r_opy  <= r_p[1];
                        r_opz  <= r_p[2];
                        r_oidx <= r_vidx;
                        r_onv  <= w_closing;
                        r_onx  <= r_n[0];
                        r_ony  <= r_n[1];
                        r_onz  <= r_n[2];
                        r_odv  <= r_degv;
                        r_odf  <= r_degf;
                        r_vidx <= r_vidx + 1'b1;
                        if (w_closing) begin
                            r_corner <= '0;
                        end else begin
                            if (r_corner == '0) begin
                                for (int i = 0; i < 3; i++) r_h0[i] <= r_p[i];
                            end else begin
                                for (int i = 0; i < 3; i++) r_h1[i] <= r_p[i];
                            end
                            r_corner <= r_corner + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- config port
    logic [1:0] w_ridx;
    assign w_ridx = paddr[ASH +: 2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= RADW'(spfn_pkg::RAD_RESET);
        end else if (psel && penable && pwrite) begin
            unique case (w_ridx)
                spfn_pkg::REG_CENTER_X: r_cx  <= pwdata[W-1:0];
                spfn_pkg::REG_CENTER_Y: r_cy  <= pwdata[W-1:0];
                spfn_pkg::REG_CENTER_Z: r_cz  <= pwdata[W-1:0];
                spfn_pkg::REG_RADIUS:   r_rad <= RADW'(pwdata[W-2:0]);
                default:                r_rad <= r_rad;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            spfn_pkg::REG_CENTER_X: prdata = DW'(r_cx);
            spfn_pkg::REG_CENTER_Y: prdata = DW'(r_cy);
            spfn_pkg::REG_CENTER_Z: prdata = DW'(r_cz);
            spfn_pkg::REG_RADIUS:   prdata = DW'(r_rad);
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- ports
    assign i_vtx.ready             = (r_state == S_IDLE);
    assign o_res.valid             = r_ov;
    assign o_res.px                = r_opx;
    assign o_res.py                = r_opy;
    assign o_res.pz                = r_opz;
    assign o_res.vertex_index      = r_oidx;
    assign o_res.normal_valid      = r_onv;
    assign o_res.nx                = r_onx;
    assign o_res.ny                = r_ony;
    assign o_res.nz                = r_onz;
    assign o_res.degenerate_vertex = r_odv;
    assign o_res.degenerate_face   = r_odf;

endmodule

// ===== tb/spfn_checker.sv =====
`timescale 1ns / 1ps

// Watches the vertex and result channels and the register port, predicts each
// projected vertex (plus the face normal on every third one) and compares.
module spfn_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spfn_in_if          i_vtx,
    spfn_out_if         i_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_normals
);

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic [15:0]        idx;
        logic               nvalid;
        logic signed [15:0] nx, ny, nz;
        logic               degv, degf;
    } t_vertex_result;

    logic signed [31:0] cen [3];
    logic [30:0]        radius;
    longint             corners [6];
    int                 corner_cnt;
    logic [15:0]        vtx_count;
    t_vertex_result     expected_q [$];

    function automatic int bit_length(logic [127:0] v);
        for (int i = 127; i >= 0; i--)
            if (v[i]) return i + 1;
        return 0;
    endfunction

    // common shift so the largest magnitude lands in [2^29, 2^30)
    function automatic logic [2:0][63:0] scale_to_30(logic [2:0][127:0] m);
        logic [2:0][63:0] e;
        int mx, n;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            n = bit_length(m[i]);
            if (n > mx) mx = n;
        end
        for (int i = 0; i < 3; i++) begin
            if (mx == 0) e[i] = '0;
            else if (mx > 30) e[i] = 64'(m[i] >> (mx - 30));
            else e[i] = 64'(m[i] << (30 - mx));
        end
        return e;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] vec_length(logic [2:0][63:0] e);
        return floor_sqrt(e[0] * e[0] + e[1] * e[1] + e[2] * e[2]);
    endfunction

    function automatic logic [63:0] div_round(logic [127:0] num, logic [63:0] l);
        logic [127:0] q;
        if (l == 0) return 0;
        q = (num + {64'd0, l >> 1}) / {64'd0, l};
        return q[63:0];
    endfunction

    function automatic t_vertex_result project_vertex(logic signed [31:0] vx,
                                                      logic signed [31:0] vy,
                                                      logic signed [31:0] vz);
        t_vertex_result r;
        logic signed [31:0] vin [3];
        longint d [3], p [3], u [3], w [3], t;
        logic signed [127:0] su [3], sw [3], cr [3];
        logic [2:0][127:0] m;
        logic [2:0][63:0] e;
        logic [63:0] len, q;
        logic [15:0] n [3];
        logic neg [3];
        vin[0] = vx; vin[1] = vy; vin[2] = vz;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(vin[i]) - longint'(cen[i]);
            m[i] = 128'(d[i] < 0 ? -d[i] : d[i]);
            n[i] = '0;
        end
        r.degv = (d[0] == 0) && (d[1] == 0) && (d[2] == 0);
        if (r.degv) begin
            for (int i = 0; i < 3; i++) p[i] = longint'(cen[i]);
        end else begin
            e = scale_to_30(m);
            len = vec_length(e);
            for (int i = 0; i < 3; i++) begin
                q = div_round({64'd0, e[i]} * {97'd0, radius}, len);
                t = d[i] < 0 ? longint'(cen[i]) - longint'(q) : longint'(cen[i]) + longint'(q);
                if (t > 64'sd2147483647) t = 64'sd2147483647;
                else if (t < -64'sd2147483648) t = -64'sd2147483648;
                p[i] = t;
            end
        end
        r.nvalid = 1'b0;
        r.degf = 1'b0;
        if (corner_cnt >= spfn_pkg::CORNERS - 1) begin
            r.nvalid = 1'b1;
            for (int i = 0; i < 3; i++) begin
                u[i] = corners[3 + i] - corners[i];
                w[i] = p[i] - corners[i];
                su[i] = u[i];
                sw[i] = w[i];
            end
            cr[0] = su[1] * sw[2] - su[2] * sw[1];
            cr[1] = su[2] * sw[0] - su[0] * sw[2];
            cr[2] = su[0] * sw[1] - su[1] * sw[0];
            for (int i = 0; i < 3; i++) begin
                neg[i] = cr[i] < 0;
                m[i] = neg[i] ? -cr[i] : cr[i];
            end
            r.degf = (m[0] == 0) && (m[1] == 0) && (m[2] == 0);
            if (!r.degf) begin
                e = scale_to_30(m);
                len = vec_length(e);
                for (int i = 0; i < 3; i++) begin
                    q = div_round({64'd0, e[i]} * 128'(spfn_pkg::NORM_ONE), len);
                    if (q > spfn_pkg::NORM_ONE) q = spfn_pkg::NORM_ONE;
                    n[i] = neg[i] ? -q[15:0] : q[15:0];
                end
            end
            corner_cnt = 0;
        end else begin
            for (int i = 0; i < 3; i++) corners[3 * corner_cnt + i] = p[i];
            corner_cnt++;
        end
        r.px = p[0][31:0]; r.py = p[1][31:0]; r.pz = p[2][31:0];
        r.nx = n[0]; r.ny = n[1]; r.nz = n[2];
        r.idx = vtx_count;
        vtx_count = vtx_count + 1'b1;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex_result ex;
        if (!i_rst_n) begin
            cen[0] = '0; cen[1] = '0; cen[2] = '0;
            radius = 31'(spfn_pkg::RAD_RESET);
            corner_cnt = 0;
            vtx_count = '0;
            expected_q.delete();
            o_fail_count = 0;
            o_normals = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (spfn_pkg::t_reg_idx'(paddr[3:2]))
                    spfn_pkg::REG_CENTER_X: cen[0] = pwdata;
                    spfn_pkg::REG_CENTER_Y: cen[1] = pwdata;
                    spfn_pkg::REG_CENTER_Z: cen[2] = pwdata;
                    spfn_pkg::REG_RADIUS:   radius = pwdata[30:0];
                endcase
            end
            if (i_vtx.valid && i_vtx.ready)
                expected_q = {expected_q, project_vertex(i_vtx.vx, i_vtx.vy, i_vtx.vz)};
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual index %h",
                             $time, i_res.vertex_index);
                    o_fail_count++;
                end else begin
                    ex = expected_q.pop_front();
                    if (ex.nvalid) o_normals++;
                    compare_field("px", ex.px, i_res.px);
                    compare_field("py", ex.py, i_res.py);
                    compare_field("pz", ex.pz, i_res.pz);
                    compare_field("vertex_index", 32'(ex.idx), 32'(i_res.vertex_index));
                    compare_field("normal_valid", 32'(ex.nvalid), 32'(i_res.normal_valid));
                    compare_field("nx", 32'(ex.nx), 32'(i_res.nx));
                    compare_field("ny", 32'(ex.ny), 32'(i_res.ny));
                    compare_field("nz", 32'(ex.nz), 32'(i_res.nz));
                    compare_field("degenerate_vertex", 32'(ex.degv),
                                  32'(i_res.degenerate_vertex));
                    compare_field("degenerate_face", 32'(ex.degf),
                                  32'(i_res.degenerate_face));
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/sphere_project_flat_normal_tb.sv =====
`timescale 1ns / 1ps

module sphere_project_flat_normal_tb;

    localparam int IDLE_LIMIT  = 20000;  // watchdog limit on cycles with no accepted transfer
    localparam int LONG_HOLD   = 3000;   // long receiver stall, fills the block
    localparam int DRAIN_WAIT  = 2000;   // trailing wait for stray results

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending, normals;
    int sent = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;       // off gives stretches of back-to-back requests
    int hold_req = 0;         // long stall asked of the result side

    // shadow of the center, used only to aim vertices at it
    logic signed [31:0] cx = '0, cy = '0, cz = '0;

    spfn_in_if  vtx_if ();
    spfn_out_if res_if ();

    sphere_project_flat_normal DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spfn_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (vtx_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_normals    (normals)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: only cycles with no accepted request or result count
    always @(posedge i_clk) begin
        if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: ready drops for random gaps, plus a long hold when asked
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = gaps_on ? $urandom_range(0, 4) : 0;
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    // register write: setup, access, then back to idle on the bus
    task automatic reg_write(spfn_pkg::t_reg_idx r, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {2'(r), 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [30:0] r);
        reg_write(spfn_pkg::REG_CENTER_X, x);
        reg_write(spfn_pkg::REG_CENTER_Y, y);
        reg_write(spfn_pkg::REG_CENTER_Z, z);
        reg_write(spfn_pkg::REG_RADIUS, {1'b0, r});
        cx = x; cy = y; cz = z;
    endtask

    // one vertex request; valid stays high across back-to-back requests
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            vtx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vtx_if.valid <= 1'b1;
        vtx_if.vx <= x;
        vtx_if.vy <= y;
        vtx_if.vz <= z;
        do @(posedge i_clk); while (!vtx_if.ready);
        sent++;
    endtask

    task automatic drain();
        vtx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one coordinate: anything, near the center, on it, or at an extreme
    function automatic logic [31:0] pick_coord(logic signed [31:0] c, int kind);
        case (kind)
            0:       return $urandom;
            1:       return c + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2:       return c;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic send_random_vertex();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            send_vertex(cx, cy, cz);           // vertex on the center
        else if (kind == 1)
            send_vertex(pick_coord(cx, 3), pick_coord(cy, $urandom_range(0, 3)),
                        pick_coord(cz, $urandom_range(0, 3)));
        else if (kind < 6)
            send_vertex(pick_coord(cx, 1), pick_coord(cy, 1), pick_coord(cz, 1));
        else
            send_vertex(pick_coord(cx, 0), pick_coord(cy, 0), pick_coord(cz, 0));
    endtask

    // mostly whole triangles; some repeat a corner to force a flat face
    task automatic run_triangles(int count);
        logic [31:0] x, y, z;
        for (int t = 0; t < count; t++) begin
            if ($urandom_range(0, 7) == 0) begin
                x = pick_coord(cx, 1); y = pick_coord(cy, 1); z = pick_coord(cz, 1);
                send_vertex(x, y, z);
                send_random_vertex();
                send_vertex(x, y, z);
            end else begin
                repeat (3) send_random_vertex();
            end
            if ($urandom_range(0, 15) == 0) gaps_on = ~gaps_on;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        vtx_if.valid <= 1'b0;
        vtx_if.vx <= '0;
        vtx_if.vy <= '0;
        vtx_if.vz <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset sphere (unit radius at origin)
        send_vertex(32'h0001_0000, 32'h0, 32'h0);
        send_vertex(32'h0, 32'h0001_0000, 32'h0);
        send_vertex(32'h0, 32'h0, 32'h0001_0000);
        send_vertex(32'h0, 32'h0, 32'h0);                     // on the center
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h0000_3039, 32'h0000_3039, 32'h0000_3039);  // same point thrice
        send_vertex(32'h0000_3039, 32'h0000_3039, 32'h0000_3039);
        send_vertex(32'h0000_3039, 32'h0000_3039, 32'h0000_3039);
        send_vertex(32'h8000_0000, 32'h0, 32'h0);
        send_vertex(32'h7fff_ffff, 32'h0, 32'h0);
        send_vertex(32'h0, 32'h8000_0000, 32'h7fff_ffff);
        send_vertex(32'h0, 32'h0, 32'h0);                     // centers as corners
        send_vertex(32'h0, 32'h0, 32'h0);
        send_vertex(32'h0, 32'h0, 32'h0);
        drain();

        // largest radius with the center at the corners of the range
        set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h0, 31'h7fff_ffff);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0);     // on the center
        send_vertex(32'h0, 32'h0, 32'h8000_0000);
        run_triangles(25);
        drain();

        // small sphere, with a long stall on the result side up front
        set_sphere($urandom, $urandom, $urandom, 31'($urandom_range(1, 1 << 20)));
        hold_req = LONG_HOLD;
        run_triangles(30);
        drain();

        // zero radius: every vertex collapses onto the center
        set_sphere($urandom, $urandom, $urandom, 31'd0);
        run_triangles(15);
        drain();

        // everything random
        set_sphere($urandom, $urandom, $urandom, 31'($urandom));
        run_triangles(35);
        drain();

        set_sphere($urandom, $urandom, $urandom, 31'($urandom_range(0, 1 << 24)));
        run_triangles(35);
        drain();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d vertices (%0d closing a face) over six sphere settings,",
                 sent, normals);
        $display("including zero and full-scale radius, centered and repeated corners");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
src/spfn_pkg.sv
src/spfn_in_if.sv
src/spfn_out_if.sv
src/sphere_project_flat_normal.sv
tb/spfn_checker.sv
tb/sphere_project_flat_normal_tb.sv
